>>> hdl/tpfs_pkg.sv
// ----------------------------------------------------------------------------
// tpfs_pkg
// Shared widths, codes, types and helper functions for the triangle
// properties pipeline.
// ----------------------------------------------------------------------------
package tpfs_pkg;

    localparam int SIDE_WIDTH   = 16;
    localparam int FRAC_BITS    = 8;

    // front end widths
    localparam int PER_W        = SIDE_WIDTH + 2;
    localparam int DIF_W        = SIDE_WIDTH + 1;
    localparam int SQ_W         = 2 * SIDE_WIDTH;
    localparam int SUM_W        = SQ_W + 1;
    localparam int XN_W         = SQ_W + 2;
    localparam int M1_W         = PER_W + DIF_W;
    localparam int M2_W         = 2 * DIF_W;
    localparam int M2_LO        = M2_W / 2;
    localparam int M2_HI        = M2_W - M2_LO;
    localparam int PP_W         = M1_W + M2_HI;
    localparam int P_W          = 4 * SIDE_WIDTH + 2;
    localparam int ABC_W        = 3 * SIDE_WIDTH;

    // square root of P * 2^48, one result bit per stage
    localparam int PRE_SH       = 24;
    localparam int ROOT_W       = P_W / 2 + PRE_SH;
    localparam int REM_W        = ROOT_W + 3;

    // result widths
    localparam int ANG_W        = 16;
    localparam int AREA_W       = 23;
    localparam int INR_W        = 16;
    localparam int CIR_W        = 24;
    localparam int AREA_SH      = FRAC_BITS + 2 + PRE_SH;

    // cordic
    localparam int CORDIC_STEPS = 20;
    localparam int CW           = ROOT_W + 4;
    localparam int ZW           = 26;
    localparam int DEG_SH       = 16 - FRAC_BITS;

    // dividers
    localparam int INR_NW       = PER_W + INR_W;
    localparam int CIR_DW       = AREA_W + FRAC_BITS + 2;
    localparam int CIR_NW       = CIR_DW + CIR_W;

    localparam int BACK_STAGES  = (CIR_W > CORDIC_STEPS) ? CIR_W : CORDIC_STEPS;

    localparam logic signed [ZW-1:0] DEG16_90  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] DEG16_180 = ZW'(180 * 65536);
    localparam logic [ANG_W:0]       ANG_180   = (ANG_W + 1)'(180 << FRAC_BITS);

    // atan(2^-i) in degrees scaled by 2^16
    localparam logic signed [ZW-1:0] ATAN_DEG16 [CORDIC_STEPS] = '{
        ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945), ZW'(234379),
        ZW'(117304),  ZW'(58666),   ZW'(29335),  ZW'(14668),  ZW'(7334),
        ZW'(3667),    ZW'(1833),    ZW'(917),    ZW'(458),    ZW'(229),
        ZW'(115),     ZW'(57),      ZW'(29),     ZW'(14),     ZW'(7)
    };

    typedef enum logic [1:0] {
        SC_EQUILATERAL = 2'd0,
        SC_ISOSCELES   = 2'd1,
        SC_SCALENE     = 2'd2
    } t_side_class;

    typedef enum logic [1:0] {
        AC_OBTUSE = 2'd0,
        AC_RIGHT  = 2'd1,
        AC_ACUTE  = 2'd2
    } t_angle_class;

    typedef struct packed {
        logic                     ok;
        t_side_class              side_cls;
        t_angle_class             ang_cls;
        logic [PER_W-1:0]         per;
        logic signed [XN_W-1:0]   xn_a;
        logic signed [XN_W-1:0]   xn_b;
        logic [ABC_W-1:0]         abc;
    } t_side;

    typedef struct packed {
        logic                ok;
        t_side_class         side_cls;
        t_angle_class        ang_cls;
        logic [ANG_W-1:0]    ang_a;
        logic [ANG_W-1:0]    ang_b;
        logic [ANG_W-1:0]    ang_c;
        logic [AREA_W-1:0]   area;
        logic [PER_W-1:0]    per;
        logic [INR_W-1:0]    inr;
        logic [CIR_W-1:0]    circ;
    } t_res;

    // arithmetic shift that rounds toward zero
    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                    input int k);
        logic signed [CW-1:0] m;
        m = v[CW-1] ? -v : v;
        m = m >>> k;
        return v[CW-1] ? -m : m;
    endfunction

    // clamp to [0, 180] degrees and round half up to the output fraction
    function automatic logic [ANG_W-1:0] deg_out(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] zc;
        logic [ZW-1:0]        t;
        if (z < 0) begin
            zc = '0;
        end else if (z > DEG16_180) begin
            zc = DEG16_180;
        end else begin
            zc = z;
        end
        t = ZW'(unsigned'(zc)) + ZW'(1 << (DEG_SH - 1));
        return t[DEG_SH +: ANG_W];
    endfunction

endpackage

>>> hdl/tpfs_front.sv
// ----------------------------------------------------------------------------
// tpfs_front
// Four stage front end: squares, perimeter, classes, and the Heron
// product P = 16 * area^2 built from split partial products.
// ----------------------------------------------------------------------------
module tpfs_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [tpfs_pkg::SIDE_WIDTH-1:0]   i_a,
    input  logic [tpfs_pkg::SIDE_WIDTH-1:0]   i_b,
    input  logic [tpfs_pkg::SIDE_WIDTH-1:0]   i_c,
    output logic                              o_vld,
    output logic [tpfs_pkg::P_W-1:0]          o_p,
    output tpfs_pkg::t_side                   o_side
);
    import tpfs_pkg::*;

    // stage 1
    logic [SQ_W-1:0]   n1_a2, n1_b2, n1_c2, n1_ab;
    logic [PER_W-1:0]  n1_per;
    logic [DIF_W-1:0]  n1_s1, n1_s2, n1_s3;
    logic              n1_ok;
    t_side_class       n1_side_cls;
    logic              r1_vld;
    logic [SQ_W-1:0]   r1_a2, r1_b2, r1_c2, r1_ab;
    logic [PER_W-1:0]  r1_per;
    logic [DIF_W-1:0]  r1_s1, r1_s2, r1_s3;
    logic [SIDE_WIDTH-1:0] r1_c;
    logic              r1_ok;
    t_side_class       r1_side_cls;

    // stage 2
    logic [SUM_W-1:0]  n2_ab2, n2_bc2, n2_ca2;
    t_side             n2_side;
    logic [M1_W-1:0]   n2_m1;
    logic [M2_W-1:0]   n2_m2;
    logic              r2_vld;
    t_side             r2_side;
    logic [M1_W-1:0]   r2_m1;
    logic [M2_W-1:0]   r2_m2;

    // stage 3
    logic              r3_vld;
    t_side             r3_side;
    logic [PP_W-1:0]   r3_pl, r3_ph;

    // stage 4
    logic              r4_vld;
    t_side             r4_side;
    logic [P_W-1:0]    r4_p;

    always_comb begin
        n1_a2  = SQ_W'(i_a) * SQ_W'(i_a);
        n1_b2  = SQ_W'(i_b) * SQ_W'(i_b);
        n1_c2  = SQ_W'(i_c) * SQ_W'(i_c);
        n1_ab  = SQ_W'(i_a) * SQ_W'(i_b);
        n1_per = PER_W'(i_a) + PER_W'(i_b) + PER_W'(i_c);
        n1_s1  = DIF_W'(i_b) + DIF_W'(i_c) - DIF_W'(i_a);
        n1_s2  = DIF_W'(i_c) + DIF_W'(i_a) - DIF_W'(i_b);
        n1_s3  = DIF_W'(i_a) + DIF_W'(i_b) - DIF_W'(i_c);
        n1_ok  = (DIF_W'(i_a) + DIF_W'(i_b) > DIF_W'(i_c)) &&
                 (DIF_W'(i_b) + DIF_W'(i_c) > DIF_W'(i_a)) &&
                 (DIF_W'(i_c) + DIF_W'(i_a) > DIF_W'(i_b));
        if (i_a == i_b && i_b == i_c) begin
            n1_side_cls = SC_EQUILATERAL;
        end else if (i_a == i_b || i_a == i_c || i_b == i_c) begin
            n1_side_cls = SC_ISOSCELES;
        end else begin
            n1_side_cls = SC_SCALENE;
        end
    end

    always_comb begin
        n2_bc2 = SUM_W'(r1_b2) + SUM_W'(r1_c2);
        n2_ca2 = SUM_W'(r1_c2) + SUM_W'(r1_a2);
        n2_ab2 = SUM_W'(r1_a2) + SUM_W'(r1_b2);
        n2_side.ok       = r1_ok;
        n2_side.side_cls = r1_side_cls;
        n2_side.per      = r1_per;
        if (SUM_W'(r1_a2) > n2_bc2 || SUM_W'(r1_b2) > n2_ca2 ||
            SUM_W'(r1_c2) > n2_ab2) begin
            n2_side.ang_cls = AC_OBTUSE;
        end else if (SUM_W'(r1_a2) == n2_bc2 || SUM_W'(r1_b2) == n2_ca2 ||
                     SUM_W'(r1_c2) == n2_ab2) begin
            n2_side.ang_cls = AC_RIGHT;
        end else begin
            n2_side.ang_cls = AC_ACUTE;
        end
        n2_side.xn_a = $signed(XN_W'(n2_bc2)) - $signed(XN_W'(r1_a2));
        n2_side.xn_b = $signed(XN_W'(n2_ca2)) - $signed(XN_W'(r1_b2));
        n2_side.abc  = ABC_W'(r1_ab) * ABC_W'(r1_c);
        n2_m1 = M1_W'(r1_per) * M1_W'(r1_s1);
        n2_m2 = M2_W'(r1_s2) * M2_W'(r1_s3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a2       <= n1_a2;
            r1_b2       <= n1_b2;
            r1_c2       <= n1_c2;
            r1_ab       <= n1_ab;
            r1_c        <= i_c;
            r1_per      <= n1_per;
            r1_s1       <= n1_s1;
            r1_s2       <= n1_s2;
            r1_s3       <= n1_s3;
            r1_ok       <= n1_ok;
            r1_side_cls <= n1_side_cls;
            r2_side     <= n2_side;
            r2_m1       <= n2_m1;
            r2_m2       <= n2_m2;
            // 35 x 34 product taken as two 35 x 17 halves
            r3_side     <= r2_side;
            r3_pl       <= PP_W'(r2_m1) * PP_W'(r2_m2[M2_LO-1:0]);
            r3_ph       <= PP_W'(r2_m1) * PP_W'(r2_m2[M2_W-1:M2_LO]);
            r4_side     <= r3_side;
            r4_p        <= P_W'(r3_pl) + P_W'({r3_ph, {M2_LO{1'b0}}});
        end
    end

    assign o_vld  = r4_vld;
    assign o_p    = r4_p;
    assign o_side = r4_side;

endmodule

>>> hdl/tpfs_sqrt.sv
// ----------------------------------------------------------------------------
// tpfs_sqrt
// Pipelined restoring square root of P * 2^48, one root bit per stage.
// ----------------------------------------------------------------------------
module tpfs_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [tpfs_pkg::P_W-1:0]      i_p,
    input  tpfs_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic [tpfs_pkg::ROOT_W-1:0]   o_root,
    output tpfs_pkg::t_side               o_side
);
    import tpfs_pkg::*;

    localparam int RAD_STAGES = P_W / 2;

    logic              r_vld  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_q    [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-2];
    logic [P_W-1:0]    r_rad  [0:RAD_STAGES-2];
    t_side             r_side [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              c_vld;
        logic [ROOT_W-1:0] c_q;
        logic [REM_W-1:0]  c_rem;
        logic [P_W-1:0]    c_rad;
        t_side             c_side;
        logic [REM_W-1:0]  c_sh;
        logic [REM_W-1:0]  c_trial;
        logic              c_take;

        if (k == 0) begin : g_head
            assign c_vld  = i_vld;
            assign c_q    = '0;
            assign c_rem  = '0;
            assign c_side = i_side;
        end else begin : g_link
            assign c_vld  = r_vld[k-1];
            assign c_q    = r_q[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_side = r_side[k-1];
        end

        // the low 48 bits of the radicand are all zeros
        if (k == 0) begin : g_rad_in
            assign c_rad = i_p;
        end else if (k < RAD_STAGES) begin : g_rad_link
            assign c_rad = r_rad[k-1];
        end else begin : g_rad_zero
            assign c_rad = '0;
        end

        assign c_sh    = {c_rem[REM_W-3:0], c_rad[P_W-1 -: 2]};
        assign c_trial = REM_W'({c_q, 2'b01});
        assign c_take  = (c_sh >= c_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= c_side;
                r_q[k]    <= {c_q[ROOT_W-2:0], c_take};
            end
        end

        if (k < ROOT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= c_take ? (c_sh - c_trial) : c_sh;
                end
            end
        end

        if (k < RAD_STAGES - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k] <= {c_rad[P_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_q[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

>>> hdl/tpfs_back.sv
// ----------------------------------------------------------------------------
// tpfs_back
// Back end: two cordic vectoring lanes for the angles, and two restoring
// dividers for inradius and circumradius, run side by side over the same
// stages; result formatting after the last stage.
// ----------------------------------------------------------------------------
module tpfs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [tpfs_pkg::ROOT_W-1:0]   i_root,
    input  tpfs_pkg::t_side               i_side,
    output logic                          o_vld,
    output tpfs_pkg::t_res                o_res
);
    import tpfs_pkg::*;

    localparam int NB = BACK_STAGES;

    logic              r_vld  [0:NB-1];
    t_side             r_side [0:NB-1];
    logic [AREA_W-1:0] r_area [0:NB-1];

    // cordic lanes: 0 for the angle at a, 1 for the angle at b
    logic signed [CW-1:0] r_vx [0:1][0:CORDIC_STEPS-2];
    logic signed [CW-1:0] r_vy [0:1][0:CORDIC_STEPS-2];
    logic signed [ZW-1:0] r_z  [0:1][0:NB-1];

    logic [INR_NW-1:0] r_irem [0:INR_W-2];
    logic [INR_W-1:0]  r_iq   [0:NB-1];
    logic              r_isat [0:NB-1];

    logic [CIR_NW-1:0] r_crem [0:CIR_W-2];
    logic [CIR_DW-1:0] r_cd   [0:CIR_W-2];
    logic [CIR_W-1:0]  r_cq   [0:NB-1];
    logic              r_csat [0:NB-1];

    logic [AREA_W-1:0] c_area0;
    logic [INR_NW-1:0] c_irem0;
    logic              c_isat0;
    logic [CIR_DW-1:0] c_cd0;
    logic [CIR_NW-1:0] c_crem0;
    logic              c_csat0;

    always_comb begin
        c_area0 = i_root[AREA_SH +: AREA_W];
        c_irem0 = INR_NW'({c_area0, {(FRAC_BITS + 1){1'b0}}});
        c_isat0 = (c_irem0 >= INR_NW'({i_side.per, {INR_W{1'b0}}}));
        c_cd0   = CIR_DW'({c_area0, {(FRAC_BITS + 2){1'b0}}});
        c_crem0 = CIR_NW'(i_side.abc);
        // a zero area saturates the circumradius
        c_csat0 = (c_area0 == '0) || (c_crem0 >= CIR_NW'({c_cd0, {CIR_W{1'b0}}}));
    end

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic              c_vld;
        t_side             c_side;
        logic [AREA_W-1:0] c_area;

        if (k == 0) begin : g_head
            assign c_vld  = i_vld;
            assign c_side = i_side;
            assign c_area = c_area0;
        end else begin : g_link
            assign c_vld  = r_vld[k-1];
            assign c_side = r_side[k-1];
            assign c_area = r_area[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= c_side;
                r_area[k] <= c_area;
            end
        end

        // ---------------- cordic lanes ----------------
        for (genvar j = 0; j < 2; j++) begin : g_lane
            logic signed [CW-1:0] c_vx, c_vy, c_dx, c_dy;
            logic signed [ZW-1:0] c_z;

            if (k == 0) begin : g_init
                logic signed [XN_W-1:0] c_xn;
                logic [XN_W-1:0]        c_mag;
                logic signed [CW-1:0]   c_xs;
                always_comb begin
                    c_xn  = (j == 0) ? i_side.xn_a : i_side.xn_b;
                    c_mag = c_xn[XN_W-1] ? XN_W'(-c_xn) : XN_W'(c_xn);
                    c_xs  = $signed(CW'(c_mag) << PRE_SH);
                    c_vx  = $signed(CW'(i_root));
                    c_vy  = c_xn[XN_W-1] ? c_xs : -c_xs;
                    c_z   = DEG16_90;
                end
            end else if (k < CORDIC_STEPS) begin : g_link
                assign c_vx = r_vx[j][k-1];
                assign c_vy = r_vy[j][k-1];
                assign c_z  = r_z[j][k-1];
            end else begin : g_tail
                assign c_vx = '0;
                assign c_vy = '0;
                assign c_z  = r_z[j][k-1];
            end

            if (k < CORDIC_STEPS) begin : g_rot
                assign c_dx = shr_tz(c_vy, k);
                assign c_dy = shr_tz(c_vx, k);
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_z[j][k] <= c_vy[CW-1] ? (c_z - ATAN_DEG16[k])
                                                : (c_z + ATAN_DEG16[k]);
                    end
                end
                if (k < CORDIC_STEPS - 1) begin : g_vec
                    always_ff @(posedge i_clk) begin
                        if (i_en) begin
                            r_vx[j][k] <= c_vy[CW-1] ? (c_vx - c_dx) : (c_vx + c_dx);
                            r_vy[j][k] <= c_vy[CW-1] ? (c_vy + c_dy) : (c_vy - c_dy);
                        end
                    end
                end
            end else begin : g_hold
                assign c_dx = '0;
                assign c_dy = '0;
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_z[j][k] <= c_z + ZW'(c_dx) - ZW'(c_dy) + ZW'(c_vx - c_vy);
                    end
                end
            end
        end

        // ---------------- inradius divider ----------------
        if (k < NB) begin : g_inr
            logic [INR_W-1:0]  c_q;
            logic              c_sat;
            if (k == 0) begin : g_init
                assign c_q   = '0;
                assign c_sat = c_isat0;
            end else begin : g_link
                assign c_q   = r_iq[k-1];
                assign c_sat = r_isat[k-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_isat[k] <= c_sat;
                end
            end

            if (k < INR_W) begin : g_step
                localparam int SH = INR_W - 1 - k;
                logic [INR_NW-1:0] c_rem;
                logic [INR_NW:0]   c_trial;
                if (k == 0) begin : g_r0
                    assign c_rem = c_irem0;
                end else begin : g_rl
                    assign c_rem = r_irem[k-1];
                end
                assign c_trial = {1'b0, c_rem} - ((INR_NW + 1)'(c_side.per) << SH);
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_iq[k] <= {c_q[INR_W-2:0], ~c_trial[INR_NW]};
                    end
                end
                if (k < INR_W - 1) begin : g_keep
                    always_ff @(posedge i_clk) begin
                        if (i_en) begin
                            r_irem[k] <= c_trial[INR_NW] ? c_rem : c_trial[INR_NW-1:0];
                        end
                    end
                end
            end else begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_iq[k] <= c_q;
                    end
                end
            end
        end

        // ---------------- circumradius divider ----------------
        if (k < NB) begin : g_cir
            logic [CIR_W-1:0]  c_q;
            logic              c_sat;
            if (k == 0) begin : g_init
                assign c_q   = '0;
                assign c_sat = c_csat0;
            end else begin : g_link
                assign c_q   = r_cq[k-1];
                assign c_sat = r_csat[k-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_csat[k] <= c_sat;
                end
            end

            if (k < CIR_W) begin : g_step
                localparam int SH = CIR_W - 1 - k;
                logic [CIR_NW-1:0] c_rem;
                logic [CIR_DW-1:0] c_d;
                logic [CIR_NW:0]   c_trial;
                if (k == 0) begin : g_r0
                    assign c_rem = c_crem0;
                    assign c_d   = c_cd0;
                end else begin : g_rl
                    assign c_rem = r_crem[k-1];
                    assign c_d   = r_cd[k-1];
                end
                assign c_trial = {1'b0, c_rem} - ((CIR_NW + 1)'(c_d) << SH);
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_cq[k] <= {c_q[CIR_W-2:0], ~c_trial[CIR_NW]};
                    end
                end
                if (k < CIR_W - 1) begin : g_keep
                    always_ff @(posedge i_clk) begin
                        if (i_en) begin
                            r_crem[k] <= c_trial[CIR_NW] ? c_rem : c_trial[CIR_NW-1:0];
                            r_cd[k]   <= c_d;
                        end
                    end
                end
            end else begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_cq[k] <= c_q;
                    end
                end
            end
        end
    end

    // ---------------- result formatting ----------------
    logic [ANG_W-1:0] c_ang_a, c_ang_b;
    logic [ANG_W:0]   c_ang_sum;
    t_side            c_last;

    always_comb begin
        c_last    = r_side[NB-1];
        c_ang_a   = deg_out(r_z[0][NB-1]);
        c_ang_b   = deg_out(r_z[1][NB-1]);
        c_ang_sum = (ANG_W + 1)'(c_ang_a) + (ANG_W + 1)'(c_ang_b);

        o_res.ok       = c_last.ok;
        o_res.side_cls = c_last.side_cls;
        o_res.ang_cls  = c_last.ang_cls;
        o_res.per      = c_last.per;
        if (c_last.ok) begin
            o_res.ang_a = c_ang_a;
            o_res.ang_b = c_ang_b;
            o_res.ang_c = (c_ang_sum >= ANG_180) ? '0 : ANG_W'(ANG_180 - c_ang_sum);
            o_res.area  = r_area[NB-1];
            o_res.inr   = r_isat[NB-1] ? '1 : r_iq[NB-1];
            o_res.circ  = r_csat[NB-1] ? '1 : r_cq[NB-1];
        end else begin
            o_res.ang_a = '0;
            o_res.ang_b = '0;
            o_res.ang_c = '0;
            o_res.area  = '0;
            o_res.inr   = '0;
            o_res.circ  = '0;
        end
    end

    assign o_vld = r_vld[NB-1];

endmodule

>>> hdl/triangle_properties_from_sides_core.sv
// ----------------------------------------------------------------------------
// triangle_properties_from_sides_core
// Triangle validity, classes, angles, Heron area, perimeter and radii from
// three Q8.8 side lengths.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one request of three sides.
//   Output channel o_out_valid / i_out_ready returns one result per request,
//   in request order. Both follow valid/ready; a transfer happens on a clock
//   edge with both high.
//   The path runs through 4 front stages (squares, classes, the Heron
//   product), 57 square root stages (one root bit each), 24 back stages
//   (20 cordic steps per angle beside the inradius and circumradius
//   dividers) and the output register.
//   Throughput is one request per cycle while not stalled: every stage is a
//   register with its own valid bit and a new request can enter each cycle.
//   When the receiver holds i_out_ready low with a result waiting, the whole
//   pipeline freezes and o_in_ready drops in the same cycle; nothing in
//   flight is lost or repeated. Empty stages freeze too, so bubbles stay
//   where they are until the result is taken.
//   Synchronous reset (i_rst_n low) clears all valid bits; the pipeline is
//   empty and ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module triangle_properties_from_sides_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [tpfs_pkg::SIDE_WIDTH-1:0]    i_side_a,
    input  logic [tpfs_pkg::SIDE_WIDTH-1:0]    i_side_b,
    input  logic [tpfs_pkg::SIDE_WIDTH-1:0]    i_side_c,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_is_valid,
    output logic [tpfs_pkg::ANG_W-1:0]         o_angle_at_a,
    output logic [tpfs_pkg::ANG_W-1:0]         o_angle_at_b,
    output logic [tpfs_pkg::ANG_W-1:0]         o_angle_at_c,
    output logic [1:0]                         o_side_class,
    output logic [1:0]                         o_angle_class,
    output logic [tpfs_pkg::AREA_W-1:0]        o_area,
    output logic [tpfs_pkg::PER_W-1:0]         o_perimeter,
    output logic [tpfs_pkg::INR_W-1:0]         o_inradius,
    output logic [tpfs_pkg::CIR_W-1:0]         o_circumradius
);
    import tpfs_pkg::*;

    logic              en;
    logic              fr_vld, sq_vld, bk_vld;
    logic [P_W-1:0]    fr_p;
    t_side             fr_side, sq_side;
    logic [ROOT_W-1:0] sq_root;
    t_res              bk_res;
    logic              r_out_vld;
    t_res              r_res;

    // advance when the output slot is empty or being drained
    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    tpfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid),
        .i_a     (i_side_a),
        .i_b     (i_side_b),
        .i_c     (i_side_c),
        .o_vld   (fr_vld),
        .o_p     (fr_p),
        .o_side  (fr_side)
    );

    tpfs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (fr_vld),
        .i_p     (fr_p),
        .i_side  (fr_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    tpfs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_vld   (bk_vld),
        .o_res   (bk_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= bk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= bk_res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_is_valid     = r_res.ok;
    assign o_angle_at_a   = r_res.ang_a;
    assign o_angle_at_b   = r_res.ang_b;
    assign o_angle_at_c   = r_res.ang_c;
    assign o_side_class   = r_res.side_cls;
    assign o_angle_class  = r_res.ang_cls;
    assign o_area         = r_res.area;
    assign o_perimeter    = r_res.per;
    assign o_inradius     = r_res.inr;
    assign o_circumradius = r_res.circ;

endmodule

>>> hdl/tpfs_checker.sv
// ----------------------------------------------------------------------------
// tpfs_checker
// Port level checks for the triangle properties core, bound to the top.
// ----------------------------------------------------------------------------
module tpfs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_is_valid,
    input logic [tpfs_pkg::ANG_W-1:0]        o_angle_at_a,
    input logic [tpfs_pkg::ANG_W-1:0]        o_angle_at_b,
    input logic [tpfs_pkg::ANG_W-1:0]        o_angle_at_c,
    input logic [1:0]                        o_side_class,
    input logic [1:0]                        o_angle_class,
    input logic [tpfs_pkg::AREA_W-1:0]       o_area,
    input logic [tpfs_pkg::INR_W-1:0]        o_inradius,
    input logic [tpfs_pkg::CIR_W-1:0]        o_circumradius
);
    import tpfs_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a waiting result freezes the pipeline and blocks new requests
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while output stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_valid |-> o_angle_at_a == '0 && o_angle_at_b == '0 &&
            o_angle_at_c == '0 && o_area == '0 && o_inradius == '0 &&
            o_circumradius == '0)
        else $error("nonzero geometry on invalid triangle");

    a_equi_acute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_valid && o_side_class == SC_EQUILATERAL |->
            o_angle_class == AC_ACUTE)
        else $error("equilateral triangle not acute");

endmodule

bind triangle_properties_from_sides_core tpfs_checker u_tpfs_checker (.*);
